>>> rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// shared types and constants for the extended euclid modular inverse block
// ----------------------------------------------------------------------------
package mie_pkg;

	localparam int unsigned WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_COPRIME = 2'd1,
		ST_BAD_MODULUS = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK_N,
		S_DIV_INIT,
		S_CHECK_R,
		S_DIV_STEP,
		S_MUL_GO,
		S_MUL_WAIT,
		S_UPDATE,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the input word
		logic div_go;    // start the shared divider
		logic div_init;  // divider operands: value / modulus, else r0 / r1
		logic init_r1;   // r1 takes the first remainder
		logic mul_go;    // start the shift-add multiply-accumulate
		logic update;    // advance the remainder and coefficient sequences
		logic finish;    // register the result word
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic n_small;   // modulus below two
		logic div_done;
		logic r1_zero;
		logic mul_idle;
	} sts_t;

endpackage

>>> rtl/mie_div.sv
// ----------------------------------------------------------------------------
// mie_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mie_div #(
	parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quo,
	output logic [WIDTH-1:0] rem
);
	import mie_pkg::*;

	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] d_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (run_q) begin
			// trial subtract of the divisor from the partial remainder
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> rtl/mie_dp.sv
// ----------------------------------------------------------------------------
// mie_dp
// datapath: remainder and coefficient registers, divider, shift-add mac
// ----------------------------------------------------------------------------
module mie_dp #(
	parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mie_pkg::cmd_t      cmd,
	output mie_pkg::sts_t      sts,
	input  logic [WIDTH-1:0]   modulus,
	input  logic [WIDTH-1:0]   value,
	output logic [WIDTH-1:0]   inverse,
	output logic [WIDTH-1:0]   divisor,
	output mie_pkg::status_t   status
);
	import mie_pkg::*;

	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] v_q;
	logic [WIDTH-1:0] r0_q;
	logic [WIDTH-1:0] r1_q;
	logic [WIDTH-1:0] c0_q;
	logic [WIDTH-1:0] c1_q;
	logic             neg0_q;
	logic             neg1_q;
	logic [WIDTH-1:0] mq_q;
	logic [WIDTH-1:0] mc_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] inv_q;
	logic [WIDTH-1:0] gcd_q;
	status_t          st_q;

	logic [WIDTH-1:0] div_a;
	logic [WIDTH-1:0] div_b;
	logic             div_done;
	logic [WIDTH-1:0] div_quo;
	logic [WIDTH-1:0] div_rem;
	logic [WIDTH-1:0] m;
	logic [WIDTH-1:0] inv_ok;

	assign div_a = cmd.div_init ? v_q : r0_q;
	assign div_b = cmd.div_init ? n_q : r1_q;

	mie_div #(
		.WIDTH(WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.div_go),
		.dividend(div_a),
		.divisor (div_b),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// coefficient magnitude never exceeds n, so one compare reduces it
	assign m      = (c0_q == n_q) ? '0 : c0_q;
	assign inv_ok = (neg0_q && (m != '0)) ? (n_q - m) : m;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= modulus;
			v_q    <= value;
			r0_q   <= modulus;
			c0_q   <= '0;
			c1_q   <= {{(WIDTH-1){1'b0}}, 1'b1};
			neg0_q <= 1'b0;
			neg1_q <= 1'b0;
		end
		if (cmd.init_r1) begin
			r1_q <= div_rem;
		end
		// c2 = c0 + q * c1, one multiplier bit per cycle
		if (cmd.mul_go) begin
			acc_q <= c0_q;
			mq_q  <= div_quo;
			mc_q  <= c1_q;
		end else if (mq_q != '0) begin
			if (mq_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mq_q <= mq_q >> 1;
			mc_q <= mc_q << 1;
		end
		if (cmd.update) begin
			r0_q   <= r1_q;
			r1_q   <= div_rem;
			c0_q   <= c1_q;
			neg0_q <= neg1_q;
			c1_q   <= acc_q;
			neg1_q <= !neg1_q;
		end
		if (cmd.finish) begin
			if (n_q < WIDTH'(2)) begin
				inv_q <= '0;
				gcd_q <= (n_q == '0) ? v_q : {{(WIDTH-1){1'b0}}, 1'b1};
				st_q  <= ST_BAD_MODULUS;
			end else if (r0_q == {{(WIDTH-1){1'b0}}, 1'b1}) begin
				inv_q <= inv_ok;
				gcd_q <= r0_q;
				st_q  <= ST_OK;
			end else begin
				inv_q <= '0;
				gcd_q <= r0_q;
				st_q  <= ST_NOT_COPRIME;
			end
		end
	end

	assign sts.n_small  = (n_q < WIDTH'(2));
	assign sts.div_done = div_done;
	assign sts.r1_zero  = (r1_q == '0);
	assign sts.mul_idle = (mq_q == '0);

	assign inverse = inv_q;
	assign divisor = gcd_q;
	assign status  = st_q;

endmodule

>>> rtl/mie_ctrl.sv
// ----------------------------------------------------------------------------
// mie_ctrl
// controller: sequences the euclid steps over the shared divider and mac
// ----------------------------------------------------------------------------
module mie_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output mie_pkg::cmd_t cmd,
	input  mie_pkg::sts_t sts
);
	import mie_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FINISH);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK_N;
				end
			end
			S_CHECK_N: begin
				if (sts.n_small) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_go   = 1'b1;
					cmd.div_init = 1'b1;
					state_d      = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				if (sts.div_done) begin
					cmd.init_r1 = 1'b1;
					state_d     = S_CHECK_R;
				end
			end
			S_CHECK_R: begin
				if (sts.r1_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_go = 1'b1;
					state_d    = S_DIV_STEP;
				end
			end
			S_DIV_STEP: begin
				if (sts.div_done) begin
					state_d = S_MUL_GO;
				end
			end
			S_MUL_GO: begin
				cmd.mul_go = 1'b1;
				state_d    = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (sts.mul_idle) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_CHECK_R;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> rtl/modular_inverse_ext_euclid.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// gcd and modular inverse of a value by the extended euclidean algorithm
// ----------------------------------------------------------------------------
//  channel   handshake       word
//  input     start & !busy   modulus, value
//  result    done (1 cycle)  inverse, divisor, status
//
//  one word at a time; each euclid step runs the shared divider, then the shift-add
//  mac until no multiplier bits of q are left, then the control states that check
//  the remainder and update the sequences; a modulus below two skips the divider
//  and goes straight to the result
//  done pulses in the cycle after the finish state registers the result, busy is low again by then
//  reset clears the control registers only; the receiver cannot stall
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
	parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [WIDTH-1:0] modulus,
	input  logic [WIDTH-1:0] value,
	output logic             done,
	output logic [WIDTH-1:0] inverse,
	output logic [WIDTH-1:0] divisor,
	output mie_pkg::status_t status
);
	import mie_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mie_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.sts   (sts)
	);

	mie_dp #(
		.WIDTH(WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.modulus(modulus),
		.value  (value),
		.inverse(inverse),
		.divisor(divisor),
		.status (status)
	);

endmodule
